[rtl/brdu_pkg.sv]
package brdu_pkg;

  localparam int unsigned MtN = 312;
  localparam int unsigned MtM = 156;
  localparam int unsigned PosW = 9;
  localparam logic [63:0] MtMatrix  = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] MtUpper   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MtLower   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MtInitMul = 64'd6364136223846793005;
  localparam logic [31:0] MtInitMulLo = MtInitMul[31:0];
  localparam logic [31:0] MtInitMulHi = MtInitMul[63:32];
  localparam int unsigned UnitShift = 11;

  localparam logic [1:0] FuncIndex  = 2'd0;
  localparam logic [1:0] FuncUnit   = 2'd1;
  localparam logic [1:0] FuncAccept = 2'd2;

  // Unsigned 64-bit remainder request/response between top and divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rem;
  } div_rsp_t;

  function automatic logic [63:0] temper(input logic [63:0] y_in);
    logic [63:0] y;
    y = y_in;
    y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
    y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
    y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

[rtl/brdu_rem.sv]
module brdu_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  brdu_pkg::div_req_t req,
  output brdu_pkg::div_rsp_t rsp
);
  import brdu_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [64:0] shifted;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[63:0], quo_r[63]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      quo_nxt  = req.dividend;
      rem_nxt  = 65'd0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[62:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[63:0];

endmodule

[rtl/bounded_random_draw_unit.sv]
// Bounded random draw unit: an MT19937-64 generator serving draw requests.
// Input channel in_*: one beat is one request. in_tuser holds func (2 bits),
// in_tdata holds upper_bound [63:0], accept_threshold [127:64] and
// accept_certain [128]. Output channel out_*: one beat per request, out_tdata
// holds draw_value [63:0] and accepted [64].
// cfg_we/cfg_wdata write the seed; write only while the unit is idle. A write
// alone does nothing; the generator reseeds before the next draw if the seed
// differs from the last seed used or it was never seeded.
// A no-draw request goes from S_DECODE straight to S_OUT; a unit or accept draw
// passes S_DRAW, S_RD and S_USE on the way. Once every 312 words a refill pass
// runs first (S_RF_A to S_THR per word over the single-port word memory). A
// reseed runs before it; the seeding multiply runs on one 32x32 unit.
// An index request computes 2^64 mod bound on the remainder unit, draws
// until a word passes (a redraw repeats S_DRAW, S_RD, S_USE), then reduces
// it on the same unit. in_tready rises at the same edge as out_tvalid. Reset
// clears position to 312, the seeded flag and last seed; word memory content
// stays undefined until seeded. One request is in the core at a time; a
// stalled receiver holds the result in the output register while the core
// takes the next request and holds it in S_OUT.
module bounded_random_draw_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [135:0]  in_tdata,  // upper_bound, accept_threshold, accept_certain
  input  logic [1:0]    in_tuser,  // func
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [71:0]   out_tdata  // draw_value, accepted
);
  import brdu_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_SEED   = 14'b00000000000100,
    S_SEEDM  = 14'b00000000001000,
    S_DRAW   = 14'b00000000010000,
    S_RF_A   = 14'b00000000100000,
    S_RF_B   = 14'b00000001000000,
    S_RF_C   = 14'b00000010000000,
    S_RD     = 14'b00000100000000,
    S_USE    = 14'b00001000000000,
    S_MOD    = 14'b00010000000000,
    S_MODW   = 14'b00100000000000,
    S_THR    = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] seed_r;
  logic [63:0] last_seed_r;
  logic        seeded_r;
  logic [PosW-1:0] pos_r;
  logic [PosW-1:0] idx_r;
  logic [1:0]  ph_r;
  logic [1:0]  func_r;
  logic [63:0] bound_r, thr_r;
  logic        cert_r;
  logic [63:0] rej_r;
  logic [63:0] prev_r;
  logic [63:0] prod_r;
  logic [63:0] w_i_r;
  logic [63:0] xa_r;
  logic [63:0] val_r;
  logic        acc_r;
  logic [63:0] oval_r;
  logic        oacc_r;
  logic        ovalid_r;
  logic        out_load;

  // word memory, one port
  logic [63:0] mem [MtN];
  logic [PosW-1:0] mem_addr;
  logic        mem_we;
  logic [63:0] mem_wd;
  logic [63:0] mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_rd_r <= mem[mem_addr];
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  brdu_rem u_rem (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  logic [63:0] tempered;
  logic [63:0] seed_z;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] twist_x;
  logic [63:0] twist_xa;
  logic [PosW-1:0] idx_p1, idx_pm;
  logic [PosW:0] idx_sum;

  assign tempered  = temper(mem_rd_r);
  assign seed_z    = prev_r ^ (prev_r >> 62);
  assign twist_x   = (w_i_r & MtUpper) | (mem_rd_r & MtLower);
  assign twist_xa  = (twist_x >> 1) ^ (twist_x[0] ? MtMatrix : 64'd0);
  assign idx_p1    = (idx_r == PosW'(MtN - 1)) ? '0 : idx_r + PosW'(1);
  assign idx_sum   = {1'b0, idx_r} + (PosW+1)'(MtM);
  assign idx_pm    = (idx_sum >= (PosW+1)'(MtN)) ? PosW'(idx_sum - (PosW+1)'(MtN))
                                                 : idx_sum[PosW-1:0];

  // Seeding product, low 64 bits only: lo*lo, then the two cross terms
  // added into the upper half, one 32x32 product per phase.
  always_comb begin
    case (ph_r)
      2'd0: begin
        mul_a = seed_z[31:0];
        mul_b = MtInitMulLo;
      end
      2'd1: begin
        mul_a = seed_z[63:32];
        mul_b = MtInitMulLo;
      end
      default: begin
        mul_a = seed_z[31:0];
        mul_b = MtInitMulHi;
      end
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, oacc_r, oval_r};
  assign out_load   = (state_r == S_OUT) && (!ovalid_r || out_tready);

  logic need_seed;
  assign need_seed = !seeded_r || (last_seed_r != seed_r);

  // memory address and write
  always_comb begin
    mem_addr = pos_r;
    mem_we   = 1'b0;
    mem_wd   = prod_r + 64'(idx_r);
    case (state_r)
      S_SEED: begin
        mem_addr = '0;
        mem_we   = 1'b1;
        mem_wd   = seed_r;
      end
      S_SEEDM: begin
        mem_addr = idx_r;
        mem_we   = (ph_r == 2'd3);
      end
      S_RF_A:  mem_addr = idx_r;
      S_RF_B:  mem_addr = idx_p1;
      S_RF_C:  mem_addr = idx_pm;
      S_THR: begin
        mem_addr = idx_r;
        mem_we   = 1'b1;
        mem_wd   = mem_rd_r ^ xa_r;
      end
      S_RD:    mem_addr = idx_r;
      default: mem_addr = pos_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    case (state_r)
      S_IDLE:   if (in_tvalid && in_tready) state_nxt = S_DECODE;
      S_DECODE: begin
        state_nxt = S_OUT;
        if (func_r == FuncIndex && bound_r > 64'd1) begin
          div_req.start    = 1'b1;
          div_req.dividend = 64'd0 - bound_r;
          div_req.divisor  = bound_r;
          state_nxt = S_MOD;
        end else if (func_r == FuncUnit ||
                     (func_r == FuncAccept && !cert_r && thr_r != 64'd0)) begin
          state_nxt = need_seed ? S_SEED : S_DRAW;
        end
      end
      S_MOD:    if (div_rsp.done) state_nxt = need_seed ? S_SEED : S_DRAW;
      S_SEED:   state_nxt = S_SEEDM;
      S_SEEDM:  if (ph_r == 2'd3 && idx_r == PosW'(MtN - 1)) state_nxt = S_DRAW;
      S_DRAW:   state_nxt = (pos_r >= PosW'(MtN)) ? S_RF_A : S_RD;
      S_RF_A:   state_nxt = S_RF_B;
      S_RF_B:   state_nxt = S_RF_C;
      S_RF_C:   state_nxt = S_THR;
      S_THR:    state_nxt = (idx_r == PosW'(MtN - 1)) ? S_DRAW : S_RF_A;
      S_RD:     state_nxt = S_USE;
      S_USE: begin
        state_nxt = S_OUT;
        if (func_r == FuncIndex) begin
          if (tempered < rej_r) begin
            state_nxt = S_DRAW;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = tempered;
            div_req.divisor  = bound_r;
            state_nxt = S_MODW;
          end
        end
      end
      S_MODW:   if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:    state_nxt = out_load ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Refill: S_RF_A reads word i, S_RF_B latches it and reads i+1, S_RF_C
  // forms twist and reads i+m, S_THR writes word i back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= 64'd0;
      last_seed_r <= 64'd0;
      seeded_r    <= 1'b0;
      pos_r       <= PosW'(MtN);
      ovalid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) seed_r <= cfg_wdata;
      if (out_load) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_SEED: begin
          last_seed_r <= seed_r;
          seeded_r    <= 1'b1;
          pos_r       <= PosW'(MtN);
        end
        S_THR: if (idx_r == PosW'(MtN - 1)) pos_r <= '0;
        S_RD:  pos_r <= pos_r + PosW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        func_r  <= in_tuser;
        bound_r <= in_tdata[63:0];
        thr_r   <= in_tdata[127:64];
        cert_r  <= in_tdata[128];
        val_r   <= 64'd0;
        acc_r   <= 1'b0;
        idx_r   <= '0;
      end
      S_DECODE: begin
        if (func_r == FuncAccept && cert_r) acc_r <= 1'b1;
      end
      S_MOD: if (div_rsp.done) rej_r <= div_rsp.rem;
      S_SEED: begin
        prev_r <= seed_r;
        idx_r  <= PosW'(1);
        ph_r   <= 2'd0;
      end
      S_SEEDM: begin
        ph_r <= ph_r + 2'd1;
        case (ph_r)
          2'd0: prod_r <= mul_p;
          2'd1, 2'd2: prod_r[63:32] <= prod_r[63:32] + mul_p[31:0];
          default: begin
            prev_r <= mem_wd;
            idx_r  <= idx_r + PosW'(1);
          end
        endcase
      end
      S_DRAW:  idx_r <= (pos_r >= PosW'(MtN)) ? '0 : pos_r;
      S_RF_B:  w_i_r <= mem_rd_r;
      S_RF_C:  xa_r  <= twist_xa;
      S_THR:   idx_r <= (idx_r == PosW'(MtN - 1)) ? idx_r : idx_r + PosW'(1);
      S_USE: begin
        if (func_r == FuncUnit) val_r <= tempered >> UnitShift;
        if (func_r == FuncAccept) acc_r <= (tempered < thr_r);
      end
      S_MODW:  if (div_rsp.done) val_r <= div_rsp.rem;
      S_OUT: begin
        if (out_load) begin
          oval_r <= val_r;
          oacc_r <= acc_r;
        end
      end
      default: ;
    endcase
  end

endmodule

[sim/bounded_random_draw_unit_test.sv]
`timescale 1ns / 100ps

// Self-checking bench for the bounded random draw unit. Every request beat is
// run through a local MT19937-64 draw predictor; every result beat is compared
// against the oldest pending prediction. The seed register changes between
// phases, and each phase applies its own idle and stall pattern to the stream.
module bounded_random_draw_unit_test;
  import brdu_pkg::*;

  localparam int unsigned WatchLimit = 200000;
  localparam int unsigned RandItems = 500;
  localparam logic [1:0] FuncNone = 2'd3;

  typedef struct packed {
    logic [63:0] value;
    logic        acc;
  } draw_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [63:0] bound;
    logic [63:0] thr;
    logic        certain;
    logic        known;  // expected result typed in below
    logic [63:0] exp_value;
    logic        exp_acc;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [135:0] in_tdata = '0;  // upper_bound, accept_threshold, accept_certain
  logic [1:0] in_tuser = '0;    // func
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;       // draw_value, accepted

  bounded_random_draw_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Predictor copy of the generator and the seed register.
  logic [63:0] mt_words [MtN];
  int unsigned mt_pos;
  logic        mt_seeded;
  logic [63:0] mt_last_seed;
  logic [63:0] seed_reg;

  draw_result_t pending_draws[$];
  int unsigned  err_count = 0;
  int unsigned  beats_out = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  sent_count = 0;
  int unsigned  func_seen [4];

  function automatic logic [63:0] next_word();
    logic [63:0] x;
    logic [63:0] y;
    if (!mt_seeded || mt_last_seed != seed_reg) begin
      mt_words[0] = seed_reg;
      for (int i = 1; i < MtN; i++)
        mt_words[i] = MtInitMul * (mt_words[i-1] ^ (mt_words[i-1] >> 62)) + 64'(i);
      mt_pos = MtN;
      mt_last_seed = seed_reg;
      mt_seeded = 1'b1;
    end
    if (mt_pos >= MtN) begin
      for (int i = 0; i < MtN; i++) begin
        x = (mt_words[i] & MtUpper) | (mt_words[(i + 1) % MtN] & MtLower);
        mt_words[i] = mt_words[(i + MtM) % MtN] ^ (x >> 1) ^ (x[0] ? MtMatrix : 64'd0);
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y ^= (y >> 29) & 64'h5555_5555_5555_5555;
    y ^= (y << 17) & 64'h71D6_7FFF_EDA6_0000;
    y ^= (y << 37) & 64'hFFF7_EEE0_0000_0000;
    y ^= y >> 43;
    return y;
  endfunction

  function automatic draw_result_t predict_draw(logic [1:0] func, logic [63:0] bound,
                                                logic [63:0] thr, logic certain);
    draw_result_t r;
    logic [63:0] floor_rej;
    logic [63:0] w;
    r = '0;
    case (func)
      FuncIndex: begin
        if (bound > 64'd1) begin
          floor_rej = (64'd0 - bound) % bound;
          do w = next_word(); while (w < floor_rej);
          r.value = w % bound;
        end
      end
      FuncUnit: r.value = next_word() >> UnitShift;
      FuncAccept: begin
        if (certain) r.acc = 1'b1;
        else if (thr != 64'd0) r.acc = (next_word() < thr);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one request beat; hold valid until the handshake, then record it.
  // Valid stays up after the beat so the next request can follow at once.
  task automatic send_request(logic [1:0] func, logic [63:0] bound, logic [63:0] thr,
                              logic certain);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {7'd0, certain, thr, bound};
    do @(posedge clk); while (!in_tready);
    pending_draws.push_back(predict_draw(func, bound, thr, certain));
    func_seen[func]++;
    sent_count++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Change the seed only while nothing is in flight.
  task automatic write_seed(logic [63:0] s);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_reg = s;
  endtask

  // Random request: mostly draws, biased toward interesting bounds and thresholds.
  task automatic send_random();
    logic [1:0] f;
    logic [63:0] b;
    logic [63:0] t;
    f = ($urandom_range(19) == 0) ? FuncNone : 2'($urandom_range(2));
    case ($urandom_range(5))
      0: b = 64'($urandom_range(3));
      1: b = 64'($urandom_range(1000));
      2: b = {1'b1, 63'($urandom)} + 64'($urandom);  // heavy rejection region
      default: b = {$urandom, $urandom};
    endcase
    case ($urandom_range(5))
      0: t = 64'd0;
      1: t = '1;
      default: t = {$urandom, $urandom};
    endcase
    send_request(f, b, t, $urandom_range(3) == 0);
  endtask

  // Receiver: stall at random, check each result beat against the oldest prediction.
  always @(posedge clk) begin
    draw_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        beats_out++;
        if (pending_draws.size() == 0) begin
          $display("%0t: result beat with nothing pending, actual %h", $time, out_tdata);
          err_count++;
        end else begin
          want = pending_draws.pop_front();
          if (out_tdata[63:0] !== want.value) begin
            $display("%0t: draw_value expected %h actual %h", $time, want.value,
                     out_tdata[63:0]);
            err_count++;
          end
          if (out_tdata[64] !== want.acc) begin
            $display("%0t: accepted expected %b actual %b", $time, want.acc, out_tdata[64]);
            err_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results pending", pending_draws.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  request_row_t directed_rows[$];

  function automatic request_row_t row(logic [1:0] f, logic [63:0] b, logic [63:0] t,
                                       logic c, logic k, logic [63:0] v, logic a);
    request_row_t r;
    r.func = f; r.bound = b; r.thr = t; r.certain = c;
    r.known = k; r.exp_value = v; r.exp_acc = a;
    return r;
  endfunction

  initial begin
    logic [63:0] seed_list [5];
    draw_result_t typed;
    int unsigned phase_items;
    mt_pos = MtN;
    mt_seeded = 1'b0;
    mt_last_seed = '0;
    seed_reg = '0;
    foreach (func_seen[i]) func_seen[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // No-draw cases first: generator never seeded, results fixed.
    directed_rows.push_back(row(FuncIndex, 64'd0, '0, 1'b0, 1'b1, 64'd0, 1'b0));
    directed_rows.push_back(row(FuncIndex, 64'd1, '1, 1'b1, 1'b1, 64'd0, 1'b0));
    directed_rows.push_back(row(FuncAccept, '1, '0, 1'b1, 1'b1, 64'd0, 1'b1));
    directed_rows.push_back(row(FuncAccept, '1, '1, 1'b1, 1'b1, 64'd0, 1'b1));
    directed_rows.push_back(row(FuncAccept, '0, '0, 1'b0, 1'b1, 64'd0, 1'b0));
    directed_rows.push_back(row(FuncNone, '1, '1, 1'b1, 1'b1, 64'd0, 1'b0));
    // First draws from seed zero, then extremes of each field.
    directed_rows.push_back(row(FuncUnit, '0, '0, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncIndex, 64'd2, '0, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncIndex, 64'd3, '0, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncIndex, '1, '0, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncIndex, 64'h8000_0000_0000_0001, '0, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncAccept, '0, 64'd1, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncAccept, '0, '1, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncAccept, '1, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0, 1'b0));
    directed_rows.push_back(row(FuncUnit, '1, '1, 1'b1, 1'b0, '0, 1'b0));

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].func, directed_rows[i].bound, directed_rows[i].thr,
                   directed_rows[i].certain);
      if (directed_rows[i].known) begin
        typed = pending_draws[$];
        if (typed.value !== directed_rows[i].exp_value || typed.acc !== directed_rows[i].exp_acc)
          begin
          $display("%0t: row %0d predictor expected %h/%b got %h/%b", $time, i,
                   directed_rows[i].exp_value, directed_rows[i].exp_acc, typed.value, typed.acc);
          err_count++;
        end
      end
    end
    // Hold off the sender until every result is back.
    drain_results();

    seed_list = '{64'd5489, '1, 64'h0123_4567_89AB_CDEF, 64'd0, 64'd5489};
    for (int ph = 0; ph < 5; ph++) begin
      write_seed(ph == 2 ? {$urandom, $urandom} : seed_list[ph]);
      if (ph == 3) write_seed(seed_reg);  // rewrite same value: no reseed expected
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      phase_items = (ph == 0) ? 300 : RandItems / 8;  // phase 0 spans a refill
      repeat (phase_items) send_random();
    end
    drain_results();

    $display("covered %0d requests (index %0d, unit %0d, accept %0d, none %0d)",
             sent_count, func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
    $display("five seed settings, idle and stall mixes, %0d results checked", beats_out);
    if (err_count == 0 && pending_draws.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
